/* rtl/cellular_pair_spring_force_unit_defines.svh */
// Assertion macros for the pair spring force unit.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef CELLULAR_PAIR_SPRING_FORCE_UNIT_DEFINES_SVH
`define CELLULAR_PAIR_SPRING_FORCE_UNIT_DEFINES_SVH

// Condition or implication checked at every clock edge outside reset.
`define CPSF_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define CPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cpsf_pkg.sv */
// Shared types, constants and helpers of the pair spring force unit.
// No dependencies.
`default_nettype none
package cpsf_pkg;

  localparam int unsigned NumStages = 75;
  localparam int unsigned SqSteps   = 33;
  localparam int unsigned DivSteps  = 31;
  localparam int unsigned EDivSteps = 17;

  localparam logic [1:0] KindPairFF = 2'b00;
  localparam logic [1:0] KindPairSS = 2'b11;

  typedef enum logic [2:0] {
    CFG_CELL_RADIUS  = 3'd0,
    CFG_CONTACT_AREA = 3'd1,
    CFG_HALF_STEP    = 3'd2,
    CFG_SHEAR_FF     = 3'd3,
    CFG_SHEAR_CROSS  = 3'd4,
    CFG_SHEAR_SS     = 3'd5
  } cfg_idx_e;

  // Per-pair info carried through squaring and square root.
  typedef struct packed {
    logic            want;
    logic            contact;
    logic [1:0]      kind;
    logic [2:0]      dneg;
    logic [2:0][32:0] dm;
  } side_t;

  typedef struct packed {
    logic [65:0] x;
    logic [65:0] res;
  } root_t;

  // Per-pair state through the division and scaling stages.
  typedef struct packed {
    logic             want;
    logic             contact;
    logic             rzero;
    logic             eneg;
    logic             pneg;
    logic [1:0]       kind;
    logic [2:0]       dneg;
    logic [32:0]      r;
    logic [2:0][63:0] cx;
    logic [2:0][30:0] cq;
    logic [49:0]      ex;
    logic [16:0]      eq;
    logic [32:0]      smag;
    logic [46:0]      pmag;
    logic [33:0]      enraw;
    logic [30:0]      energy;
  } post_t;

  typedef struct packed {
    logic        want;
    logic        contact;
    logic        rzero;
    logic        pneg;
    logic [2:0]  dneg;
    logic [30:0] energy;
  } tail_t;

  // One digit of the integer square root; bit weight 4^(32-i).
  function automatic root_t root_step(input root_t cur, input int i);
    root_t       nxt;
    logic [65:0] bitw;
    logic [65:0] sum;
    bitw = 66'(1) << (64 - 2 * i);
    sum  = cur.res + bitw;
    if (cur.x >= sum) begin
      nxt.x   = cur.x - sum;
      nxt.res = (cur.res >> 1) + bitw;
    end else begin
      nxt.x   = cur.x;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

  // Saturate the Q1.30 x Q16.16 product to signed Q16.16.
  function automatic logic [31:0] sat_force(input logic neg, input logic [77:0] m);
    logic [47:0] q;
    logic [31:0] res;
    q = m[77:30];
    if (neg) begin
      res = (q >= 48'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      res = (q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/cellular_pair_spring_force_unit.sv */
// Pair spring force unit: one neighbor pair in, one force/energy beat out.
// Throughput one beat per cycle while the output is not stalled.
// Its depth is set by the 33-digit square root and the 31-bit restoring dividers.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads R = 1.0, A = 1.0, other config registers 0.
// Depends on cpsf_pkg and cellular_pair_spring_force_unit_defines.svh.
`default_nettype none
`include "cellular_pair_spring_force_unit_defines.svh"

module cellular_pair_spring_force_unit
  import cpsf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [30:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_dx, pos_dy, pos_dz, vel_dx, vel_dy, vel_dz, want_energy, zero pad
  input  wire logic [199:0] s_axis_tdata,
  // first_kind, second_kind
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // force_x, force_y, force_z, pair_energy, in_contact
  output logic [127:0]      m_axis_tdata
);

  // ---------------------------------------------------------------- config
  logic [30:0] cell_radius_q, contact_area_q, half_step_q;
  logic [30:0] shear_ff_q, shear_cross_q, shear_ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_radius_q  <= 31'd65536;
      contact_area_q <= 31'd65536;
      half_step_q    <= '0;
      shear_ff_q     <= '0;
      shear_cross_q  <= '0;
      shear_ss_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CELL_RADIUS:  cell_radius_q  <= cfg_data_i;
        CFG_CONTACT_AREA: contact_area_q <= cfg_data_i;
        CFG_HALF_STEP:    half_step_q    <= cfg_data_i;
        CFG_SHEAR_FF:     shear_ff_q     <= cfg_data_i;
        CFG_SHEAR_CROSS:  shear_cross_q  <= cfg_data_i;
        CFG_SHEAR_SS:     shear_ss_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cutoff threshold 144*R^2 (25*|d|^2 is compared against it); the user must keep
  // config static while beats are in flight (the block does not enforce this), so run it freely.
  logic [61:0] rr_q;
  logic [69:0] thr_q;
  always_ff @(posedge clk_i) begin
    rr_q  <= 62'(cell_radius_q) * 62'(cell_radius_q);
    thr_q <= 70'(rr_q) * 70'(144);
  end

  logic [31:0] two_r;
  assign two_r = {cell_radius_q, 1'b0};

  // ---------------------------------------------------------- flow control
  // One enable for every stage: advance unless the output beat is stuck.
  logic                 ce;
  logic [NumStages-1:0] vld_q;

  assign ce            = !vld_q[NumStages-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  // ------------------------------------------------------ input unpacking
  logic [31:0] in_pos [3];
  logic [31:0] in_vel [3];
  logic [31:0] vmag   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_pos[k] = s_axis_tdata[32*k +: 32];
      in_vel[k] = s_axis_tdata[96+32*k +: 32];
      vmag[k]   = in_vel[k][31] ? (~in_vel[k] + 32'd1) : in_vel[k];
    end
  end

  // ------------------------------------------------------- datapath regs
  logic [62:0]  a_prod_q [3];
  logic [31:0]  a_pos_q  [3];
  logic [2:0]   a_vneg_q;
  logic [1:0]   a_kind_q;
  logic         a_want_q;

  side_t        b_side_q;
  logic [46:0]  b_dm_q   [3];

  side_t        c_side_q;
  logic [47:0]  c_pp00_q [3];
  logic [46:0]  c_pp01_q [3];
  logic [45:0]  c_pp11_q [3];

  side_t        d_side_q;
  logic [93:0]  d_sq_q   [3];

  side_t        e_side_q;
  logic [95:0]  e_rsq_q;

  side_t        f_side_q;
  logic [100:0] f_lhs_q;
  logic [65:0]  f_rsq_q;

  root_t        rt_q [SqSteps+1];
  side_t        sd_q [SqSteps+1];

  post_t        pst_q [DivSteps+1];

  tail_t        g_tail_q;
  logic [54:0]  g_lo_q [3];
  logic [53:0]  g_hi_q [3];

  tail_t        h_tail_q;
  logic [77:0]  h_m_q  [3];

  logic [127:0] out_q;

  // Combinational helpers for the front stages.
  logic signed [47:0] dsum [3];
  side_t              b_side_d;
  side_t              sd0_d;
  post_t              pst0_d;
  logic [32:0]        root_r;
  logic [32:0]        diff_r;

  always_comb begin
    b_side_d         = '0;
    b_side_d.want    = a_want_q;
    b_side_d.kind    = a_kind_q;
    for (int k = 0; k < 3; k++) begin
      // Advance the separation half a step: d = p +/- (half_step*|v| >> 16).
      dsum[k] = a_vneg_q[k]
              ? (48'(signed'(a_pos_q[k])) - signed'(48'(a_prod_q[k][62:16])))
              : (48'(signed'(a_pos_q[k])) + signed'(48'(a_prod_q[k][62:16])));
      b_side_d.dneg[k] = dsum[k][47];
      b_side_d.dm[k]   = dsum[k][47] ? 33'(-dsum[k]) : 33'(dsum[k]);
    end
  end

  // Cutoff test result rides along with the pair into the root stages.
  always_comb begin
    sd0_d         = f_side_q;
    sd0_d.contact = f_lhs_q < 101'(thr_q);
  end

  // Seed the dividers from the root: strain numerator |r - 2R| << 16 and
  // direction numerators |d_k| << 30 over r.
  always_comb begin
    root_r         = rt_q[SqSteps].res[32:0];
    pst0_d         = '0;
    pst0_d.want    = sd_q[SqSteps].want;
    pst0_d.contact = sd_q[SqSteps].contact;
    pst0_d.kind    = sd_q[SqSteps].kind;
    pst0_d.dneg    = sd_q[SqSteps].dneg;
    pst0_d.r       = root_r;
    pst0_d.rzero   = (root_r == '0);
    pst0_d.eneg    = root_r < 33'(two_r);
    diff_r         = pst0_d.eneg ? (33'(two_r) - root_r) : (root_r - 33'(two_r));
    pst0_d.ex      = 50'(diff_r) << 16;
    for (int k = 0; k < 3; k++) begin
      pst0_d.cx[k] = 64'(sd_q[SqSteps].dm[k]) << 30;
    end
  end

  // One quotient bit of each divider per stage, plus the strain scaling
  // steps once the strain quotient is complete.
  function automatic post_t post_step(input post_t cur, input int j);
    post_t       nxt;
    logic [63:0] dv;
    logic [49:0] den;
    logic [30:0] g;
    logic [49:0] sprod;
    logic [63:0] pprod;
    logic [49:0] eprod;
    int          db;
    int          eb;
    nxt = cur;
    db  = DivSteps - 1 - j;
    for (int k = 0; k < 3; k++) begin
      dv = 64'(cur.r) << db;
      if (cur.cx[k] >= dv) begin
        nxt.cx[k]     = cur.cx[k] - dv;
        nxt.cq[k][db] = 1'b1;
      end
    end
    if (j < EDivSteps) begin
      eb  = EDivSteps - 1 - j;
      den = 50'(two_r) << eb;
      if (cur.ex >= den) begin
        nxt.ex     = cur.ex - den;
        nxt.eq[eb] = 1'b1;
      end
    end else if (j == EDivSteps) begin
      if (cur.kind == KindPairFF) begin
        g = shear_ff_q;
      end else if (cur.kind == KindPairSS) begin
        g = shear_ss_q;
      end else begin
        g = shear_cross_q;
      end
      sprod    = 50'(cur.eq) * 50'({g, 1'b0});
      nxt.smag = sprod[48:16];
    end else if (j == EDivSteps + 1) begin
      pprod     = 64'(contact_area_q) * 64'(cur.smag);
      nxt.pmag  = pprod[62:16];
      eprod     = 50'(cur.smag) * 50'(cur.eq);
      nxt.enraw = eprod[49:16];
    end else if (j == EDivSteps + 2) begin
      nxt.energy = (cur.enraw > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : cur.enraw[30:0];
      nxt.pneg   = cur.eneg && (cur.pmag != '0);
    end
    return nxt;
  endfunction

  always_ff @(posedge clk_i) begin
    if (ce) begin
      // Multiply half_step by |v| per axis.
      for (int k = 0; k < 3; k++) begin
        a_prod_q[k] <= 63'(half_step_q) * 63'(vmag[k]);
        a_pos_q[k]  <= in_pos[k];
        a_vneg_q[k] <= in_vel[k][31];
      end
      a_kind_q <= s_axis_tuser;
      a_want_q <= s_axis_tdata[192];

      // Predicted separation, as sign and magnitude.
      b_side_q <= b_side_d;
      for (int k = 0; k < 3; k++) begin
        b_dm_q[k] <= dsum[k][47] ? 47'(-dsum[k]) : 47'(dsum[k]);
      end

      // Square each magnitude in three partial products.
      c_side_q <= b_side_q;
      for (int k = 0; k < 3; k++) begin
        c_pp00_q[k] <= 48'(b_dm_q[k][23:0]) * 48'(b_dm_q[k][23:0]);
        c_pp01_q[k] <= 47'(b_dm_q[k][23:0]) * 47'(b_dm_q[k][46:24]);
        c_pp11_q[k] <= 46'(b_dm_q[k][46:24]) * 46'(b_dm_q[k][46:24]);
      end

      d_side_q <= c_side_q;
      for (int k = 0; k < 3; k++) begin
        d_sq_q[k] <= 94'(c_pp00_q[k]) + (94'(c_pp01_q[k]) << 25)
                   + (94'(c_pp11_q[k]) << 48);
      end

      e_side_q <= d_side_q;
      e_rsq_q  <= 96'(d_sq_q[0]) + 96'(d_sq_q[1]) + 96'(d_sq_q[2]);

      f_side_q <= e_side_q;
      f_lhs_q  <= (101'(e_rsq_q) << 4) + (101'(e_rsq_q) << 3) + 101'(e_rsq_q);
      f_rsq_q  <= e_rsq_q[65:0];

      // Cutoff test, and load the root. Inside the cutoff |d|^2 < 2^66.
      sd_q[0]     <= sd0_d;
      rt_q[0].x   <= f_rsq_q;
      rt_q[0].res <= '0;

      for (int i = 0; i < SqSteps; i++) begin
        rt_q[i+1] <= root_step(rt_q[i], i);
        sd_q[i+1] <= sd_q[i];
      end

      pst_q[0] <= pst0_d;
      for (int j = 0; j < DivSteps; j++) begin
        pst_q[j+1] <= post_step(pst_q[j], j);
      end

      // Scale direction cosines by |p| in two partial products.
      g_tail_q.want    <= pst_q[DivSteps].want;
      g_tail_q.contact <= pst_q[DivSteps].contact;
      g_tail_q.rzero   <= pst_q[DivSteps].rzero;
      g_tail_q.pneg    <= pst_q[DivSteps].pneg;
      g_tail_q.dneg    <= pst_q[DivSteps].dneg;
      g_tail_q.energy  <= pst_q[DivSteps].energy;
      for (int k = 0; k < 3; k++) begin
        g_lo_q[k] <= 55'(pst_q[DivSteps].cq[k]) * 55'(pst_q[DivSteps].pmag[23:0]);
        g_hi_q[k] <= 54'(pst_q[DivSteps].cq[k]) * 54'(pst_q[DivSteps].pmag[46:24]);
      end

      h_tail_q <= g_tail_q;
      for (int k = 0; k < 3; k++) begin
        h_m_q[k] <= 78'(g_lo_q[k]) + (78'(g_hi_q[k]) << 24);
      end

      // Saturate; zero all outside the cutoff, force if r = 0, energy if unwanted.
      for (int k = 0; k < 3; k++) begin
        out_q[32*k +: 32] <= (h_tail_q.contact && !h_tail_q.rzero)
                           ? sat_force(h_tail_q.dneg[k] == h_tail_q.pneg, h_m_q[k])
                           : 32'd0;
      end
      out_q[126:96] <= (h_tail_q.contact && h_tail_q.want) ? h_tail_q.energy : 31'd0;
      out_q[127]    <= h_tail_q.contact;
    end
  end

  assign m_axis_tdata = out_q;

  // ------------------------------------------------------------ assertions
  `CPSF_ASSERT_NOW(a_no_contact_zero,
    (m_axis_tvalid && !m_axis_tdata[127]) |-> (m_axis_tdata[126:0] == '0),
    "force or energy out of contact")
  `CPSF_ASSERT_NOW(a_stall_blocks_input,
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready,
    "input taken during output stall")
  `CPSF_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0],
    "accepted beat lost at entry")

endmodule
`default_nettype wire
